// ===== sv/wao_pkg.sv =====
// Shared constants, codes and types of the watermark alpha overlay block.
// Depends on nothing; the top level, the checker and the testbench import it.
`timescale 1ns / 1ps

package wao_pkg;

	// Overlay store geometry and frame limit.
	localparam int OVL_W       = 256;
	localparam int OVL_H       = 256;
	localparam int FRAME_DIM   = 4096;
	localparam int STORE_DEPTH = OVL_W * OVL_H;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	// Field widths fixed by the interface.
	localparam int PIX_W    = 8;
	localparam int COORD_W  = 12;
	localparam int DIM_W    = 13;
	localparam int WIN_W    = 9;
	localparam int SECS_W   = 20;
	localparam int REM_W    = 16;
	localparam int ENTRY_W  = 4 * PIX_W;
	localparam int CSUB_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// One remainder bit is resolved per divider stage.
	localparam int DIV_STEPS = SECS_W;

	// The result queue holds every pixel that can be in flight, so the
	// pipeline itself never has to stop.
	localparam int FIFO_DEPTH = 2 ** $clog2(DIV_STEPS + 6);
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int OCC_W      = FIFO_PTR_W + 1;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_PIXEL = 1'b1
	} req_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_X      = 3'd0,
		REG_POS_Y      = 3'd1,
		REG_WIN_WIDTH  = 3'd2,
		REG_WIN_HEIGHT = 3'd3,
		REG_ON_TIME    = 3'd4,
		REG_INTERVAL   = 3'd5,
		REG_CHROMA_SUB = 3'd6
	} cfg_reg_e;

	// An item as it travels the modulo pipeline.
	typedef struct packed {
		req_e               req;
		logic               wr_ok;
		logic               in_win;
		logic               cw;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] wdata;
		logic [SECS_W-1:0]  secs;
		logic [REM_W-1:0]   rem;
		logic [PIX_W-1:0]   luma;
		logic [PIX_W-1:0]   cb;
		logic [PIX_W-1:0]   cr;
	} item_t;

	// A pixel after the show decision, waiting for its blend.
	typedef struct packed {
		logic             hit;
		logic             cw;
		logic [PIX_W-1:0] luma;
		logic [PIX_W-1:0] cb;
		logic [PIX_W-1:0] cr;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic [PIX_W-1:0] cb;
		logic [PIX_W-1:0] cr;
		logic             cw;
	} result_t;

endpackage

// ===== sv/wao_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// Stand-alone; sized by its WIDTH and DEPTH parameters.
`timescale 1ns / 1ps

module wao_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== sv/watermark_alpha_overlay_top.sv =====
// Top level of the watermark alpha overlay compositor.
// Uses wao_pkg for its constants and types and wao_ram for the overlay store.
//
//  Channel   Direction  Handshake            Payload
//  in        sink       in_valid / in_stall  req_type, ovl_*, pix_*, frame_seconds
//  out       source     out_valid/out_stall  out_luma, out_cb, out_cr, chroma_write
//  cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One beat is taken every cycle while in_stall is low. A pixel beat passes
// through the modulo pipeline, which resolves one remainder bit
// of frame_seconds modulo interval per stage over 20 stages, followed by the
// store read and a two-stage blend. Reset clears the configuration, the
// valid bits and the queue but not the overlay store, so the block is
// ready in the first cycle after reset. Input stall rises only when the
// result queue could overflow, which happens only after the output stalls.
`timescale 1ns / 1ps

module watermark_alpha_overlay_top import wao_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [15:0]           ovl_addr,
	input  logic [PIX_W-1:0]      ovl_luma,
	input  logic [PIX_W-1:0]      ovl_cb,
	input  logic [PIX_W-1:0]      ovl_cr,
	input  logic [PIX_W-1:0]      ovl_alpha,
	input  logic [COORD_W-1:0]    pix_x,
	input  logic [COORD_W-1:0]    pix_y,
	input  logic [SECS_W-1:0]     frame_seconds,
	input  logic [PIX_W-1:0]      pix_luma,
	input  logic [PIX_W-1:0]      pix_cb,
	input  logic [PIX_W-1:0]      pix_cr,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      out_luma,
	output logic [PIX_W-1:0]      out_cb,
	output logic [PIX_W-1:0]      out_cr,
	output logic                  chroma_write,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic [COORD_W-1:0] pos_x_q;
	logic [COORD_W-1:0] pos_y_q;
	logic [WIN_W-1:0]   win_width_q;
	logic [WIN_W-1:0]   win_height_q;
	logic [REM_W-1:0]   on_time_q;
	logic [REM_W-1:0]   interval_q;
	logic [CSUB_W-1:0]  chroma_sub_q;

	// Input side.
	logic               in_acc;
	item_t              in_item;
	logic [DIM_W-1:0]   eff_w;
	logic [DIM_W-1:0]   eff_h;
	logic [DIM_W-1:0]   dx;
	logic [DIM_W-1:0]   dy;
	logic               in_frame;
	logic               in_col;
	logic               in_row;

	// Modulo pipeline.
	item_t              div_q [DIV_STEPS+1];
	item_t              div_d [DIV_STEPS];
	logic [REM_W:0]     trial [DIV_STEPS];
	logic [DIV_STEPS:0] div_vld_q;

	// Store access and blend.
	item_t              tail;
	logic               tail_vld;
	logic               shown;
	logic               ram_we;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               vld_s1;
	pix_t               pix_s1;
	logic               vld_s2;
	pix_t               pix_s2;
	logic [2*PIX_W-1:0] pf_s2 [3];
	logic [2*PIX_W-1:0] po_s2 [3];
	logic [PIX_W-1:0]   frm   [3];
	logic [PIX_W-1:0]   ovl   [3];
	logic [PIX_W-1:0]   alpha;
	logic [2*PIX_W:0]   sum   [3];
	logic [2*PIX_W:0]   quo   [3];
	result_t            push_res;

	// Result queue.
	result_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [OCC_W-1:0]      fifo_cnt_q;
	logic [OCC_W-1:0]      occ_q;
	logic                  push;
	logic                  pop;
	logic                  acc_pix;
	result_t               head;

	// ------------------------------------------------------------------
	// Configuration. Writes are always taken.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			win_width_q  <= WIN_W'(256);
			win_height_q <= WIN_W'(256);
			on_time_q    <= '0;
			interval_q   <= '0;
			chroma_sub_q <= CSUB_W'(3);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POS_X:      pos_x_q      <= cfg_data[COORD_W-1:0];
				REG_POS_Y:      pos_y_q      <= cfg_data[COORD_W-1:0];
				REG_WIN_WIDTH:  win_width_q  <= cfg_data[WIN_W-1:0];
				REG_WIN_HEIGHT: win_height_q <= cfg_data[WIN_W-1:0];
				REG_ON_TIME:    on_time_q    <= cfg_data[REM_W-1:0];
				REG_INTERVAL:   interval_q   <= cfg_data[REM_W-1:0];
				REG_CHROMA_SUB: chroma_sub_q <= cfg_data[CSUB_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input beat: window test, store address and chroma alignment are
	// settled here; the show decision waits for the remainder.
	// ------------------------------------------------------------------
	assign in_acc  = in_valid && !in_stall;
	assign acc_pix = in_acc && (req_e'(req_type) == REQ_PIXEL);

	always_comb begin
		// The window is clipped to the size of the overlay store.
		eff_w = (DIM_W'(win_width_q) < DIM_W'(OVL_W)) ? DIM_W'(win_width_q) : DIM_W'(OVL_W);
		eff_h = (DIM_W'(win_height_q) < DIM_W'(OVL_H)) ? DIM_W'(win_height_q) : DIM_W'(OVL_H);
		dx = DIM_W'(pix_x - pos_x_q);
		dy = DIM_W'(pix_y - pos_y_q);
		in_frame = (32'(pix_x) < 32'(FRAME_DIM)) && (32'(pix_y) < 32'(FRAME_DIM));
		in_col = (pix_x >= pos_x_q) && (dx < eff_w);
		in_row = (pix_y >= pos_y_q) && (dy < eff_h);

		in_item        = '0;
		in_item.req    = req_e'(req_type);
		in_item.wr_ok  = 32'(ovl_addr) < 32'(STORE_DEPTH);
		in_item.in_win = in_frame && in_col && in_row;
		// Chroma is written when the row or the column sits on the
		// subsampling grid; with no halving every pixel writes.
		in_item.cw     = ((pix_y[0] & chroma_sub_q[1]) == 1'b0) ||
		                 ((pix_x[0] & chroma_sub_q[0]) == 1'b0);
		if (req_e'(req_type) == REQ_LOAD) begin
			in_item.addr = ADDR_W'(ovl_addr);
		end else begin
			in_item.addr = ADDR_W'(32'(dy) * OVL_W + 32'(dx));
		end
		in_item.wdata  = {ovl_alpha, ovl_cr, ovl_cb, ovl_luma};
		in_item.secs   = frame_seconds;
		in_item.rem    = '0;
		in_item.luma   = pix_luma;
		in_item.cb     = pix_cb;
		in_item.cr     = pix_cr;
	end

	// ------------------------------------------------------------------
	// Modulo pipeline: restoring remainder, most significant bit first.
	// Loads ride along so that they reach the store in beat order.
	// ------------------------------------------------------------------
	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			div_d[k] = div_q[k];
			trial[k] = {div_q[k].rem, div_q[k].secs[SECS_W-1-k]};
			if (trial[k] >= {1'b0, interval_q}) begin
				trial[k] = trial[k] - {1'b0, interval_q};
			end
			div_d[k].rem = trial[k][REM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_q <= '0;
		end else begin
			div_vld_q <= {div_vld_q[DIV_STEPS-1:0], in_acc};
		end
	end

	always_ff @(posedge clk) begin
		div_q[0] <= in_item;
		for (int k = 0; k < DIV_STEPS; k++) begin
			div_q[k+1] <= div_d[k];
		end
	end

	// ------------------------------------------------------------------
	// Store access. Only one item is at this point in any cycle, and a
	// load written here is seen by a read in the next cycle, so the
	// order of loads and pixels needs no forwarding.
	// ------------------------------------------------------------------
	assign tail     = div_q[DIV_STEPS];
	assign tail_vld = div_vld_q[DIV_STEPS];
	assign shown    = (interval_q == '0) || (tail.rem < on_time_q);
	assign ram_we   = tail_vld && (tail.req == REQ_LOAD) && tail.wr_ok;

	wao_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (tail.addr),
		.wdata (tail.wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= tail_vld && (tail.req == REQ_PIXEL);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1.hit  <= tail.in_win && shown;
		pix_s1.cw   <= tail.cw;
		pix_s1.luma <= tail.luma;
		pix_s1.cb   <= tail.cb;
		pix_s1.cr   <= tail.cr;
	end

	// ------------------------------------------------------------------
	// Blend, first half: the two products of each channel.
	// ------------------------------------------------------------------
	always_comb begin
		alpha  = ram_rdata[3*PIX_W +: PIX_W];
		frm[0] = pix_s1.luma;
		frm[1] = pix_s1.cb;
		frm[2] = pix_s1.cr;
		for (int c = 0; c < 3; c++) begin
			ovl[c] = ram_rdata[c*PIX_W +: PIX_W];
		end
	end

	always_ff @(posedge clk) begin
		pix_s2 <= pix_s1;
		for (int c = 0; c < 3; c++) begin
			pf_s2[c] <= frm[c] * (PIX_W'(255) - alpha);
			po_s2[c] <= ovl[c] * alpha;
		end
	end

	// ------------------------------------------------------------------
	// Blend, second half: sum and divide by 255. For a sum below 2^16,
	// (s + (s >> 8) + 1) >> 8 equals s / 255 exactly.
	// ------------------------------------------------------------------
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = {1'b0, pf_s2[c]} + {1'b0, po_s2[c]};
			quo[c] = sum[c] + (sum[c] >> PIX_W) + (2*PIX_W+1)'(1);
		end
		push_res.cw = pix_s2.cw;
		if (pix_s2.hit) begin
			push_res.luma = quo[0][2*PIX_W-1:PIX_W];
			push_res.cb   = quo[1][2*PIX_W-1:PIX_W];
			push_res.cr   = quo[2][2*PIX_W-1:PIX_W];
		end else begin
			push_res.luma = pix_s2.luma;
			push_res.cb   = pix_s2.cb;
			push_res.cr   = pix_s2.cr;
		end
	end

	// ------------------------------------------------------------------
	// Result queue. occ_q counts pixels accepted and not yet delivered;
	// the input stalls before that count could exceed the queue.
	// ------------------------------------------------------------------
	assign push      = vld_s2;
	assign pop       = out_valid && !out_stall;
	assign in_stall  = occ_q >= OCC_W'(FIFO_DEPTH);
	assign out_valid = fifo_cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			occ_q      <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + OCC_W'(push) - OCC_W'(pop);
			occ_q      <= occ_q + OCC_W'(acc_pix) - OCC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_res;
		end
	end

	assign head         = fifo_q[rd_ptr_q];
	assign out_luma     = head.luma;
	assign out_cb       = head.cb;
	assign out_cr       = head.cr;
	assign chroma_write = head.cw;

endmodule

// ===== sv/wao_checker.sv =====
// Port-level checks for the watermark alpha overlay top level, and its bind.
// Uses wao_pkg for the request codes and the queue depth.
`timescale 1ns / 1ps

module wao_checker import wao_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             req_type,
	input logic             out_valid,
	input logic             out_stall,
	input logic [PIX_W-1:0] out_luma,
	input logic [PIX_W-1:0] out_cb,
	input logic [PIX_W-1:0] out_cr,
	input logic             chroma_write
);

	// Pixels taken in and not yet delivered, as seen on the ports.
	logic [7:0] pend_q;
	logic       in_pix;
	logic       out_beat;

	assign in_pix   = in_valid && !in_stall && (req_e'(req_type) == REQ_PIXEL);
	assign out_beat = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(in_pix) - 8'(out_beat);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_luma) && $stable(out_cb)
			&& $stable(out_cr) && $stable(chroma_write))
		else $error("stalled result beat changed or vanished");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pend_q != 8'd0)
		else $error("result beat without a pending pixel");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 8'(FIFO_DEPTH))
		else $error("more pixels pending than the result queue holds");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (pend_q >= 8'(FIFO_DEPTH)))
		else $error("input stall does not match the pending count");

endmodule

bind watermark_alpha_overlay_top wao_checker u_wao_checker (.*);

// ===== bench/watermark_alpha_overlay_top_tb.sv =====
// Self-checking testbench for the watermark alpha overlay compositor.
// Needs wao_pkg, wao_ram and watermark_alpha_overlay_top; it predicts every result itself.
// Directed cases come first, then random traffic over many register settings.
`timescale 1ns / 1ps

module watermark_alpha_overlay_top_tb;
	import wao_pkg::*;

	// A load gives no result, so before any register write the bench lets the
	// block run idle until trailing loads have reached the store.
	localparam int SETTLE_CYCLES  = 40;
	// Longest silence in a correct run is the settle pause plus one pass through
	// the block plus random stalls; the limit lies far above that.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_SHOWN      = 10;
	localparam int IDLE_PERCENT   = 33;
	// Index with no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// One input beat as the sender sees it.
	typedef struct {
		req_e                 req;
		logic [15:0]          addr;
		logic [PIX_W-1:0]     o_luma;
		logic [PIX_W-1:0]     o_cb;
		logic [PIX_W-1:0]     o_cr;
		logic [PIX_W-1:0]     o_alpha;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [SECS_W-1:0]    secs;
		logic [PIX_W-1:0]     luma;
		logic [PIX_W-1:0]     cb;
		logic [PIX_W-1:0]     cr;
	} beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  req_type = 1'b0;
	logic [15:0]           ovl_addr = '0;
	logic [PIX_W-1:0]      ovl_luma = '0;
	logic [PIX_W-1:0]      ovl_cb = '0;
	logic [PIX_W-1:0]      ovl_cr = '0;
	logic [PIX_W-1:0]      ovl_alpha = '0;
	logic [COORD_W-1:0]    pix_x = '0;
	logic [COORD_W-1:0]    pix_y = '0;
	logic [SECS_W-1:0]     frame_seconds = '0;
	logic [PIX_W-1:0]      pix_luma = '0;
	logic [PIX_W-1:0]      pix_cb = '0;
	logic [PIX_W-1:0]      pix_cr = '0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [PIX_W-1:0]      out_luma;
	logic [PIX_W-1:0]      out_cb;
	logic [PIX_W-1:0]      out_cr;
	logic                  chroma_write;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Our own copy of the register file, starting from the reset values.
	logic [COORD_W-1:0]    cur_pos_x = '0;
	logic [COORD_W-1:0]    cur_pos_y = '0;
	logic [WIN_W-1:0]      cur_win_w = 9'd256;
	logic [WIN_W-1:0]      cur_win_h = 9'd256;
	logic [15:0]           cur_on_time = '0;
	logic [15:0]           cur_interval = '0;
	logic [CSUB_W-1:0]     cur_csub = 2'd3;

	// Our own copy of the overlay store, and which entries have been loaded.
	// The block leaves the store undefined, so no pixel may read an unloaded one.
	logic [ENTRY_W-1:0]    overlay_mem [STORE_DEPTH];
	bit                    entry_loaded [STORE_DEPTH];

	result_t               pending_pixels [$];
	int                    mismatch_count = 0;
	int                    idle_run = 0;
	bit                    in_quiet = 1'b0;
	bit                    out_quiet = 1'b0;

	watermark_alpha_overlay_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.ovl_addr      (ovl_addr),
		.ovl_luma      (ovl_luma),
		.ovl_cb        (ovl_cb),
		.ovl_cr        (ovl_cr),
		.ovl_alpha     (ovl_alpha),
		.pix_x         (pix_x),
		.pix_y         (pix_y),
		.frame_seconds (frame_seconds),
		.pix_luma      (pix_luma),
		.pix_cb        (pix_cb),
		.pix_cr        (pix_cr),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_luma      (out_luma),
		.out_cb        (out_cb),
		.out_cr        (out_cr),
		.chroma_write  (chroma_write),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Window sizes after clipping to the store.
	function automatic int clip_w();
		return (int'(cur_win_w) < OVL_W) ? int'(cur_win_w) : OVL_W;
	endfunction

	function automatic int clip_h();
		return (int'(cur_win_h) < OVL_H) ? int'(cur_win_h) : OVL_H;
	endfunction

	// True when the pixel is blended: the watermark is in its shown part of
	// the interval and the pixel lies inside the clipped window. idx is then
	// the store entry that covers it.
	function automatic bit window_hit(input beat_t b, output int idx);
		int dx;
		int dy;
		idx = 0;
		if (cur_interval != 0 && (int'(b.secs) % int'(cur_interval)) >= int'(cur_on_time))
			return 1'b0;
		if (int'(b.x) >= FRAME_DIM || int'(b.y) >= FRAME_DIM)
			return 1'b0;
		dx = int'(b.x) - int'(cur_pos_x);
		dy = int'(b.y) - int'(cur_pos_y);
		if (dx < 0 || dx >= clip_w() || dy < 0 || dy >= clip_h())
			return 1'b0;
		idx = (dy * OVL_W + dx) % STORE_DEPTH;
		return 1'b1;
	endfunction

	// (frame*(255-a) + overlay*a)/255, truncated.
	function automatic logic [PIX_W-1:0] mix(input logic [PIX_W-1:0] f, o, a);
		return PIX_W'((int'(f) * (255 - int'(a)) + int'(o) * int'(a)) / 255);
	endfunction

	function automatic result_t composite(input beat_t b);
		result_t r;
		int idx;
		logic [ENTRY_W-1:0] e;
		r.luma = b.luma;
		r.cb   = b.cb;
		r.cr   = b.cr;
		if (window_hit(b, idx)) begin
			e = overlay_mem[idx];
			r.luma = mix(b.luma, e[7:0], e[31:24]);
			r.cb   = mix(b.cb, e[15:8], e[31:24]);
			r.cr   = mix(b.cr, e[23:16], e[31:24]);
		end
		// Chroma is written unless both the row and the column are off the
		// subsampling grid.
		r.cw = ((b.y[0] & cur_csub[1]) == 1'b0) || ((b.x[0] & cur_csub[0]) == 1'b0);
		return r;
	endfunction

	// Applies an accepted beat to our copy of the block.
	function automatic void absorb(input beat_t b);
		if (b.req == REQ_LOAD) begin
			overlay_mem[b.addr]  = {b.o_alpha, b.o_cr, b.o_cb, b.o_luma};
			entry_loaded[b.addr] = 1'b1;
		end else begin
			pending_pixels.push_back(composite(b));
		end
	endfunction

	// Every field random, so that the fields a beat does not use toggle too.
	function automatic beat_t noise_beat();
		beat_t b;
		b.req     = req_e'($urandom_range(1));
		b.addr    = 16'($urandom);
		b.o_luma  = PIX_W'($urandom);
		b.o_cb    = PIX_W'($urandom);
		b.o_cr    = PIX_W'($urandom);
		b.o_alpha = PIX_W'($urandom);
		b.x       = COORD_W'($urandom);
		b.y       = COORD_W'($urandom);
		b.secs    = SECS_W'($urandom);
		b.luma    = PIX_W'($urandom);
		b.cb      = PIX_W'($urandom);
		b.cr      = PIX_W'($urandom);
		return b;
	endfunction

	// Opaque and transparent entries are the interesting ends of the blend.
	function automatic logic [PIX_W-1:0] pick_alpha();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 8'd0;
		if (r < 50)
			return 8'd255;
		return PIX_W'($urandom);
	endfunction

	function automatic beat_t pixel_beat(input int x, y, secs, luma, cb, cr);
		beat_t b;
		b      = noise_beat();
		b.req  = REQ_PIXEL;
		b.x    = COORD_W'(x);
		b.y    = COORD_W'(y);
		b.secs = SECS_W'(secs);
		b.luma = PIX_W'(luma);
		b.cb   = PIX_W'(cb);
		b.cr   = PIX_W'(cr);
		return b;
	endfunction

	// Presents one beat, after random idle cycles unless in_quiet is set, and
	// holds it until it is taken. The valid stays high afterwards so that
	// back-to-back beats never see it drop.
	task automatic send_beat(input beat_t b);
		while (!in_quiet && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= b.req;
		ovl_addr      <= b.addr;
		ovl_luma      <= b.o_luma;
		ovl_cb        <= b.o_cb;
		ovl_cr        <= b.o_cr;
		ovl_alpha     <= b.o_alpha;
		pix_x         <= b.x;
		pix_y         <= b.y;
		frame_seconds <= b.secs;
		pix_luma      <= b.luma;
		pix_cb        <= b.cb;
		pix_cr        <= b.cr;
		do
			@(posedge clk);
		while (in_stall);
		absorb(b);
	endtask

	task automatic load_entry(input int addr, luma, cb, cr, alpha);
		beat_t b;
		b         = noise_beat();
		b.req     = REQ_LOAD;
		b.addr    = 16'(addr);
		b.o_luma  = PIX_W'(luma);
		b.o_cb    = PIX_W'(cb);
		b.o_cr    = PIX_W'(cr);
		b.o_alpha = PIX_W'(alpha);
		send_beat(b);
	endtask

	// Sends a pixel, loading the covering entry first if it would otherwise
	// be read before it was ever written.
	task automatic send_pixel(input beat_t b);
		int idx;
		if (window_hit(b, idx) && !entry_loaded[idx])
			load_entry(idx, $urandom_range(255), $urandom_range(255), $urandom_range(255),
				pick_alpha());
		send_beat(b);
	endtask

	// Stops the input and waits until every pixel has come back, then lets the
	// block run empty so that trailing loads have landed too.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high; program_regs lowers it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_POS_X:      cur_pos_x    = data[COORD_W-1:0];
			REG_POS_Y:      cur_pos_y    = data[COORD_W-1:0];
			REG_WIN_WIDTH:  cur_win_w    = data[WIN_W-1:0];
			REG_WIN_HEIGHT: cur_win_h    = data[WIN_W-1:0];
			REG_ON_TIME:    cur_on_time  = data;
			REG_INTERVAL:   cur_interval = data;
			REG_CHROMA_SUB: cur_csub     = data[CSUB_W-1:0];
			default: ;
		endcase
	endtask

	// Writes the whole register file while the block is idle. The bits above
	// each field are filled with noise, which the block must ignore, and the
	// unused index gets a write of its own.
	task automatic program_regs(input int px, py, w, h, on, iv, cs);
		settle();
		write_reg(REG_POS_X,      {4'($urandom), COORD_W'(px)});
		write_reg(REG_POS_Y,      {4'($urandom), COORD_W'(py)});
		write_reg(REG_WIN_WIDTH,  {7'($urandom), WIN_W'(w)});
		write_reg(REG_WIN_HEIGHT, {7'($urandom), WIN_W'(h)});
		write_reg(REG_ON_TIME,    16'(on));
		write_reg(REG_INTERVAL,   16'(iv));
		write_reg(REG_CHROMA_SUB, {14'($urandom), CSUB_W'(cs)});
		write_reg(REG_UNUSED,     16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// A random setting that lands on the extremes often.
	task automatic random_regs();
		int px;
		int py;
		int w;
		int h;
		int on;
		int iv;
		case ($urandom_range(3))
			0: px = 0;
			1: px = 4095;
			2: px = $urandom_range(64);
			default: px = $urandom_range(4095);
		endcase
		case ($urandom_range(3))
			0: py = 0;
			1: py = 4095;
			2: py = $urandom_range(64);
			default: py = $urandom_range(4095);
		endcase
		case ($urandom_range(5))
			0: w = 0;
			1: w = 1;
			2: w = 256;
			3: w = 511;
			4: w = $urandom_range(16, 1);
			default: w = $urandom_range(511);
		endcase
		case ($urandom_range(5))
			0: h = 0;
			1: h = 1;
			2: h = 256;
			3: h = 511;
			4: h = $urandom_range(16, 1);
			default: h = $urandom_range(511);
		endcase
		case ($urandom_range(2))
			0: iv = 0;
			1: iv = $urandom_range(16, 1);
			default: iv = $urandom_range(65535);
		endcase
		case ($urandom_range(3))
			0: on = 0;
			1: on = 65535;
			2: on = $urandom_range(iv + 1);
			default: on = $urandom_range(65535);
		endcase
		program_regs(px, py, w, h, on, iv, $urandom_range(3));
	endtask

	// Mostly pixels aimed at the window (and just past its edges), some
	// pixels anywhere in the frame, and some loads to arbitrary entries.
	task automatic random_item();
		beat_t b;
		int r;
		b = noise_beat();
		r = $urandom_range(99);
		if (r < 12) begin
			b.req     = REQ_LOAD;
			b.o_alpha = pick_alpha();
			send_beat(b);
		end else begin
			b.req = REQ_PIXEL;
			if (r < 80) begin
				b.x = cur_pos_x + COORD_W'($urandom_range(clip_w() + 1));
				b.y = cur_pos_y + COORD_W'($urandom_range(clip_h() + 1));
			end
			if ($urandom_range(3) == 0)
				b.secs = SECS_W'($urandom_range(40));
			send_pixel(b);
		end
	endtask

	// Reset values: a 256 by 256 window at the origin, always shown, 4:2:0.
	task automatic test_reset_defaults();
		// Opaque entry gives the overlay exactly.
		load_entry(0, 0, 0, 0, 255);
		send_pixel(pixel_beat(0, 0, 0, 255, 255, 255));
		// Transparent entry at the far corner gives the frame exactly; odd row and
		// column under 4:2:0 do not write chroma.
		load_entry(16'hFFFF, 255, 255, 255, 0);
		send_pixel(pixel_beat(255, 255, 20'hFFFFF, 0, 0, 0));
		load_entry(1, 200, 100, 50, 128);
		send_pixel(pixel_beat(1, 0, 7, 10, 20, 30));
		// Just outside the window, and the far corner of the frame.
		send_pixel(pixel_beat(256, 0, 0, 17, 34, 51));
		send_pixel(pixel_beat(0, 256, 0, 255, 0, 255));
		send_pixel(pixel_beat(4095, 4095, 20'hFFFFF, 255, 255, 255));
	endtask

	task automatic test_window_edges();
		// A window wider and taller than the store is clipped to it.
		program_regs(0, 0, 511, 300, 0, 0, 3);
		send_pixel(pixel_beat(255, 255, 0, 90, 91, 92));
		send_pixel(pixel_beat(256, 10, 0, 90, 91, 92));
		// Window at the last frame position: the corner pixel reads entry zero.
		program_regs(4095, 4095, 511, 511, 0, 0, 3);
		send_pixel(pixel_beat(4095, 4095, 0, 200, 201, 202));
		send_pixel(pixel_beat(4094, 4095, 0, 200, 201, 202));
		// An empty window passes everything.
		program_regs(4095, 4095, 0, 0, 0, 0, 3);
		send_pixel(pixel_beat(4095, 4095, 0, 200, 201, 202));
	endtask

	task automatic test_show_interval();
		// Shown for 3 seconds out of every 10.
		program_regs(0, 0, 256, 256, 3, 10, 3);
		send_pixel(pixel_beat(0, 0, 2, 255, 255, 255));
		send_pixel(pixel_beat(0, 0, 3, 255, 255, 255));
		send_pixel(pixel_beat(0, 0, 13, 255, 255, 255));
		send_pixel(pixel_beat(0, 0, 1048572, 255, 255, 255));
		// No shown time at all.
		program_regs(0, 0, 256, 256, 0, 1, 3);
		send_pixel(pixel_beat(0, 0, 0, 255, 255, 255));
		// Largest interval and shown time, largest frame time.
		program_regs(0, 0, 256, 256, 65535, 65535, 3);
		send_pixel(pixel_beat(0, 0, 20'hFFFFF, 255, 255, 255));
	endtask

	// Without halving in both directions every pixel writes its chroma.
	task automatic test_chroma_modes();
		for (int cs = 0; cs < 3; cs++) begin
			program_regs(0, 0, 256, 256, 0, 0, cs);
			send_pixel(pixel_beat(1, 1, 0, $urandom_range(255), $urandom_range(255),
				$urandom_range(255)));
		end
	endtask

	task automatic test_random_traffic();
		repeat (6) begin
			random_regs();
			repeat (160) random_item();
		end
	endtask

	// Input at full rate, first against a stalling output so that the result
	// queue fills and the input stall is exercised, then with neither side idle.
	task automatic test_back_to_back();
		random_regs();
		in_quiet = 1'b1;
		repeat (160) random_item();
		out_quiet = 1'b1;
		repeat (160) random_item();
		in_quiet  = 1'b0;
		out_quiet = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_window_edges();
		test_show_interval();
		test_chroma_modes();
		test_random_traffic();
		test_back_to_back();
		settle();
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// The receiver stalls at random except during the quiet stretch.
	always @(posedge clk) begin
		out_stall <= out_quiet ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
	end

	// Every result beat is checked against the oldest prediction.
	always @(posedge clk) begin : check_beat
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_SHOWN)
					$display("%0t: result beat with nothing expected: luma %0d cb %0d cr %0d cw %0b",
						$realtime, out_luma, out_cb, out_cr, chroma_write);
			end else begin
				want = pending_pixels.pop_front();
				if (out_luma !== want.luma || out_cb !== want.cb || out_cr !== want.cr
						|| chroma_write !== want.cw) begin
					mismatch_count++;
					if (mismatch_count <= MAX_SHOWN)
						$display("%0t: expected luma %0d cb %0d cr %0d cw %0b, got %0d %0d %0d %0b",
							$realtime, want.luma, want.cb, want.cr, want.cw,
							out_luma, out_cb, out_cr, chroma_write);
				end
			end
		end
	end

	// Ends the run if no beat moves on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule

// ===== files.f =====
sv/wao_pkg.sv
sv/wao_ram.sv
sv/watermark_alpha_overlay_top.sv
sv/wao_checker.sv
bench/watermark_alpha_overlay_top_tb.sv
